// File: src/rtc_pkg.sv
// shared types, widths and the multiply-accumulate step program of the ray caster
// no dependencies
package rtc_pkg;

  localparam int CRDW   = 32;           // vertex and origin coordinate width
  localparam int DIRW   = 18;           // direction component width
  localparam int MESHW  = 8;
  localparam int DISTW  = 31;
  localparam int CW     = CRDW + 1;     // edge and origin offset width
  localparam int XW     = 68;           // wide operand (cross product terms)
  localparam int AW     = 104;          // accumulator, holds the widest dot product
  localparam int CHUNK  = 11;           // narrow operand bits per multiply cycle
  localparam int NCHUNK = CW / CHUNK;
  localparam int CKW    = $clog2(NCHUNK);
  localparam int NSTEP  = 24;
  localparam int STEPW  = $clog2(NSTEP);
  localparam int QDEPTH = 2;
  localparam int ADDRW  = 5;
  localparam int DATAW  = 32;

  localparam logic [DISTW-1:0] DIST_MAX  = '1;
  localparam logic [DIRW-1:0]  DIR_Z_RST = 18'd65536;

  typedef enum logic [2:0] {
    REG_ORIGIN_X, REG_ORIGIN_Y, REG_ORIGIN_Z, REG_DIR_X, REG_DIR_Y, REG_DIR_Z
  } cfg_reg_e;

  typedef enum logic [1:0] {XS_E1, XS_E2, XS_P, XS_Q} xsel_e;
  typedef enum logic [1:0] {YS_D, YS_E1, YS_E2, YS_S} ysel_e;
  typedef enum logic [1:0] {DS_P, DS_Q, DS_R} dsel_e;

  // result slots of DS_R
  localparam logic [1:0] R_DET = 2'd0;
  localparam logic [1:0] R_U   = 2'd1;
  localparam logic [1:0] R_V   = 2'd2;
  localparam logic [1:0] R_T   = 2'd3;

  typedef struct packed {
    xsel_e      xg;
    logic [1:0] xi;
    ysel_e      yg;
    logic [1:0] yi;
    logic       sub;
    logic       first;
    logic       wr;
    dsel_e      dg;
    logic [1:0] di;
  } step_t;

  typedef struct packed {
    logic [2:0][CW-1:0] e1;
    logic [2:0][CW-1:0] e2;
    logic [2:0][CW-1:0] s;
    logic [MESHW-1:0]   mesh;
    logic               last;
    logic               ok;
  } tri_t;

  function automatic step_t mk(xsel_e xg, logic [1:0] xi, ysel_e yg, logic [1:0] yi,
                               logic sub, logic first, logic wr, dsel_e dg,
                               logic [1:0] di);
    step_t r;
    r.xg = xg; r.xi = xi; r.yg = yg; r.yi = yi;
    r.sub = sub; r.first = first; r.wr = wr; r.dg = dg; r.di = di;
    return r;
  endfunction

  // P = D x E2, det = E1.P, U = S.P, Q = S x E1, V = D.Q, T = E2.Q
  function automatic step_t step_f(logic [STEPW-1:0] n);
    step_t r;
    case (n)
      5'd0:  r = mk(XS_E2, 2'd2, YS_D,  2'd1, 1'b0, 1'b1, 1'b0, DS_P, 2'd0);
      5'd1:  r = mk(XS_E2, 2'd1, YS_D,  2'd2, 1'b1, 1'b0, 1'b1, DS_P, 2'd0);
      5'd2:  r = mk(XS_E2, 2'd0, YS_D,  2'd2, 1'b0, 1'b1, 1'b0, DS_P, 2'd1);
      5'd3:  r = mk(XS_E2, 2'd2, YS_D,  2'd0, 1'b1, 1'b0, 1'b1, DS_P, 2'd1);
      5'd4:  r = mk(XS_E2, 2'd1, YS_D,  2'd0, 1'b0, 1'b1, 1'b0, DS_P, 2'd2);
      5'd5:  r = mk(XS_E2, 2'd0, YS_D,  2'd1, 1'b1, 1'b0, 1'b1, DS_P, 2'd2);
      5'd6:  r = mk(XS_P,  2'd0, YS_E1, 2'd0, 1'b0, 1'b1, 1'b0, DS_R, R_DET);
      5'd7:  r = mk(XS_P,  2'd1, YS_E1, 2'd1, 1'b0, 1'b0, 1'b0, DS_R, R_DET);
      5'd8:  r = mk(XS_P,  2'd2, YS_E1, 2'd2, 1'b0, 1'b0, 1'b1, DS_R, R_DET);
      5'd9:  r = mk(XS_P,  2'd0, YS_S,  2'd0, 1'b0, 1'b1, 1'b0, DS_R, R_U);
      5'd10: r = mk(XS_P,  2'd1, YS_S,  2'd1, 1'b0, 1'b0, 1'b0, DS_R, R_U);
      5'd11: r = mk(XS_P,  2'd2, YS_S,  2'd2, 1'b0, 1'b0, 1'b1, DS_R, R_U);
      5'd12: r = mk(XS_E1, 2'd2, YS_S,  2'd1, 1'b0, 1'b1, 1'b0, DS_Q, 2'd0);
      5'd13: r = mk(XS_E1, 2'd1, YS_S,  2'd2, 1'b1, 1'b0, 1'b1, DS_Q, 2'd0);
      5'd14: r = mk(XS_E1, 2'd0, YS_S,  2'd2, 1'b0, 1'b1, 1'b0, DS_Q, 2'd1);
      5'd15: r = mk(XS_E1, 2'd2, YS_S,  2'd0, 1'b1, 1'b0, 1'b1, DS_Q, 2'd1);
      5'd16: r = mk(XS_E1, 2'd1, YS_S,  2'd0, 1'b0, 1'b1, 1'b0, DS_Q, 2'd2);
      5'd17: r = mk(XS_E1, 2'd0, YS_S,  2'd1, 1'b1, 1'b0, 1'b1, DS_Q, 2'd2);
      5'd18: r = mk(XS_Q,  2'd0, YS_D,  2'd0, 1'b0, 1'b1, 1'b0, DS_R, R_V);
      5'd19: r = mk(XS_Q,  2'd1, YS_D,  2'd1, 1'b0, 1'b0, 1'b0, DS_R, R_V);
      5'd20: r = mk(XS_Q,  2'd2, YS_D,  2'd2, 1'b0, 1'b0, 1'b1, DS_R, R_V);
      5'd21: r = mk(XS_Q,  2'd0, YS_E2, 2'd0, 1'b0, 1'b1, 1'b0, DS_R, R_T);
      5'd22: r = mk(XS_Q,  2'd1, YS_E2, 2'd1, 1'b0, 1'b0, 1'b0, DS_R, R_T);
      5'd23: r = mk(XS_Q,  2'd2, YS_E2, 2'd2, 1'b0, 1'b0, 1'b1, DS_R, R_T);
      default: r = mk(XS_E1, 2'd0, YS_D, 2'd0, 1'b0, 1'b1, 1'b0, DS_P, 2'd0);
    endcase
    return r;
  endfunction

endpackage

// File: src/rtc_if.sv
// triangle and result channel interfaces
// depends on rtc_pkg
interface rtc_in_if;
  import rtc_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [CRDW-1:0]  a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z;
  logic [MESHW-1:0]        mesh_id;
  logic                    last;
  modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                  mesh_id, last, input ready);
  modport sink   (input valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                  mesh_id, last, output ready);
endinterface

interface rtc_out_if;
  import rtc_pkg::*;
  logic             valid;
  logic             ready;
  logic             hit;
  logic [DISTW-1:0] distance;
  logic [MESHW-1:0] hit_mesh;
  modport source (output valid, hit, distance, hit_mesh, input ready);
  modport sink   (input valid, hit, distance, hit_mesh, output ready);
endinterface

// File: src/rtc_front.sv
// front stage: takes a triangle, forms edges and origin offset, checks the mesh index
// depends on rtc_pkg, rtc_in_if
module rtc_front import rtc_pkg::*; #(
  parameter int MESH_COUNT = 256
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  rtc_in_if.sink                 tri_i,
  input  logic signed [CRDW-1:0] origin_x_i,
  input  logic signed [CRDW-1:0] origin_y_i,
  input  logic signed [CRDW-1:0] origin_z_i,
  output tri_t                   item_o,
  output logic                   item_valid_o,
  input  logic                   item_ready_i
);

  logic valid_q;
  tri_t item_q, item_d;

  assign tri_i.ready  = !valid_q || item_ready_i;
  assign item_o       = item_q;
  assign item_valid_o = valid_q;

  always_comb begin
    item_d.e1[0] = CW'(tri_i.b_x) - CW'(tri_i.a_x);
    item_d.e1[1] = CW'(tri_i.b_y) - CW'(tri_i.a_y);
    item_d.e1[2] = CW'(tri_i.b_z) - CW'(tri_i.a_z);
    item_d.e2[0] = CW'(tri_i.c_x) - CW'(tri_i.a_x);
    item_d.e2[1] = CW'(tri_i.c_y) - CW'(tri_i.a_y);
    item_d.e2[2] = CW'(tri_i.c_z) - CW'(tri_i.a_z);
    item_d.s[0]  = CW'(origin_x_i) - CW'(tri_i.a_x);
    item_d.s[1]  = CW'(origin_y_i) - CW'(tri_i.a_y);
    item_d.s[2]  = CW'(origin_z_i) - CW'(tri_i.a_z);
    item_d.mesh  = tri_i.mesh_id;
    item_d.last  = tri_i.last;
    item_d.ok    = 32'(tri_i.mesh_id) < 32'(MESH_COUNT);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (tri_i.valid && tri_i.ready) begin
      valid_q <= 1'b1;
    end else if (item_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tri_i.valid && tri_i.ready) begin
      item_q <= item_d;
    end
  end

endmodule

// File: src/rtc_fifo.sv
// short queue of prepared triangles between front and back
// depends on rtc_pkg
module rtc_fifo import rtc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  tri_t data_i,
  output logic ready_o,
  output logic valid_o,
  output tri_t data_o,
  input  logic pop_i
);

  localparam int PW = $clog2(QDEPTH);

  tri_t          mem_q [QDEPTH];
  logic [PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [PW:0]   cnt_q;
  logic          do_push, do_pop;

  assign ready_o = cnt_q != (PW + 1)'(QDEPTH);
  assign valid_o = cnt_q != '0;
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (do_push && !do_pop)      cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= data_i;
  end

endmodule

// File: src/rtc_div.sv
// restoring divider, one quotient bit per cycle, quotient known to fit DISTW bits
// depends on rtc_pkg
module rtc_div import rtc_pkg::*; #(
  parameter int NW = AW + 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NW-1:0]    num_i,
  input  logic [AW-1:0]    den_i,
  output logic             done_o,
  output logic [DISTW-1:0] quo_o
);

  localparam int CNTW = $clog2(DISTW);

  logic             busy_q, done_q;
  logic [CNTW-1:0]  cnt_q;
  logic [AW-1:0]    rem_q;
  logic [DISTW-1:0] nlo_q, quo_q;
  logic [AW:0]      trial, diff;
  logic             ge;

  assign trial  = {rem_q, nlo_q[DISTW-1]};
  assign diff   = trial - {1'b0, den_i};
  assign ge     = trial >= {1'b0, den_i};
  assign done_o = done_q;
  assign quo_o  = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNTW'(DISTW - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= AW'(num_i >> DISTW);
      nlo_q <= num_i[DISTW-1:0];
    end else if (busy_q) begin
      rem_q <= ge ? diff[AW-1:0] : trial[AW-1:0];
      nlo_q <= {nlo_q[DISTW-2:0], 1'b0};
      quo_q <= {quo_q[DISTW-2:0], ge};
    end
  end

endmodule

// File: src/rtc_back.sv
// back end: sequenced multiply-accumulate of the intersection terms, hit test,
// distance division, closest-hit tracking and the result register
// depends on rtc_pkg, rtc_out_if, rtc_div
module rtc_back import rtc_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic signed [DIRW-1:0] dir_x_i,
  input  logic signed [DIRW-1:0] dir_y_i,
  input  logic signed [DIRW-1:0] dir_z_i,
  input  tri_t                   item_i,
  input  logic                   item_valid_i,
  output logic                   item_ready_o,
  rtc_out_if.source              res_o
);

  localparam int NW   = AW + FRAC_BITS;
  localparam int CMPW = AW + DISTW;

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_ACC, S_NORM, S_CHK, S_CHK2, S_DIV, S_UPD
  } state_e;

  state_e             state_q;
  logic [2:0][CW-1:0] e1_q, e2_q, s_q;
  logic [2:0][XW-1:0] p_q, q_q;
  logic [3:0][AW-1:0] r_q;
  logic [MESHW-1:0]   mesh_q;
  logic               last_q;
  logic [STEPW-1:0]   step_q;
  logic [CKW-1:0]     chunk_q;
  logic [AW-1:0]      pm_q, acc_q, uv_q;
  logic               detz_q, sgn_ok_q, hit_q;
  logic [DISTW-1:0]   dist_q, best_t_q;
  logic               best_v_q;
  logic [MESHW-1:0]   best_mesh_q;
  logic               out_v_q, out_hit_q;
  logic [DISTW-1:0]   out_dist_q;
  logic [MESHW-1:0]   out_mesh_q;

  step_t                  st;
  logic [2:0][DIRW-1:0]   dir;
  logic signed [XW-1:0]   xv;
  logic signed [CW-1:0]   yv;
  logic [XW-1:0]          xm;
  logic [CW-1:0]          ym;
  logic [CHUNK-1:0]       ychunk;
  logic [XW+CHUNK-1:0]    prod;
  logic [AW-1:0]          pm_d, term, sum;
  logic [NW-1:0]          num;
  logic                   ge1, sat, hit_ok;
  logic                   div_start, div_done;
  logic [DISTW-1:0]       div_quo;
  logic                   take, nb_v, can_upd, emit;
  logic [DISTW-1:0]       nb_t;
  logic [MESHW-1:0]       nb_m;

  assign dir = {dir_z_i, dir_y_i, dir_x_i};
  assign st  = step_f(step_q);

  // operand selection for the current step
  always_comb begin
    case (st.xg)
      XS_E1:   xv = XW'($signed(e1_q[st.xi]));
      XS_E2:   xv = XW'($signed(e2_q[st.xi]));
      XS_P:    xv = $signed(p_q[st.xi]);
      XS_Q:    xv = $signed(q_q[st.xi]);
      default: xv = '0;
    endcase
    case (st.yg)
      YS_D:    yv = CW'($signed(dir[st.yi]));
      YS_E1:   yv = $signed(e1_q[st.yi]);
      YS_E2:   yv = $signed(e2_q[st.yi]);
      YS_S:    yv = $signed(s_q[st.yi]);
      default: yv = '0;
    endcase
  end

  assign xm     = xv[XW-1] ? XW'(-xv) : XW'(xv);
  assign ym     = yv[CW-1] ? CW'(-yv) : CW'(yv);
  assign ychunk = ym[chunk_q*CHUNK +: CHUNK];
  assign prod   = xm * ychunk;
  assign pm_d   = pm_q + (AW'(prod) << (CHUNK * chunk_q));
  assign term   = (xv[XW-1] ^ yv[CW-1] ^ st.sub) ? -pm_q : pm_q;
  assign sum    = st.first ? term : acc_q + term;

  // distance checks on the normalized terms
  assign num    = {r_q[R_T], FRAC_BITS'(0)};
  assign ge1    = num >= NW'(r_q[R_DET]);
  assign sat    = CMPW'(num) >= {r_q[R_DET], DISTW'(0)};
  assign hit_ok = sgn_ok_q && (r_q[R_DET] >= uv_q) && ge1;

  assign div_start = (state_q == S_CHK2) && hit_ok && !sat;

  rtc_div #(.NW(NW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num),
    .den_i   (r_q[R_DET]),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // closest-hit merge, first hit wins ties
  assign take    = hit_q && (!best_v_q || dist_q < best_t_q);
  assign nb_v    = best_v_q || take;
  assign nb_t    = take ? dist_q : best_t_q;
  assign nb_m    = take ? mesh_q : best_mesh_q;
  assign can_upd = !last_q || !out_v_q || res_o.ready;
  assign emit    = (state_q == S_UPD) && last_q && can_upd;

  assign item_ready_o   = state_q == S_IDLE;
  assign res_o.valid    = out_v_q;
  assign res_o.hit      = out_hit_q;
  assign res_o.distance = out_dist_q;
  assign res_o.hit_mesh = out_mesh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      e1_q        <= '0;
      e2_q        <= '0;
      s_q         <= '0;
      p_q         <= '0;
      q_q         <= '0;
      r_q         <= '0;
      mesh_q      <= '0;
      last_q      <= 1'b0;
      step_q      <= '0;
      chunk_q     <= '0;
      pm_q        <= '0;
      acc_q       <= '0;
      uv_q        <= '0;
      detz_q      <= 1'b0;
      sgn_ok_q    <= 1'b0;
      hit_q       <= 1'b0;
      dist_q      <= '0;
      best_t_q    <= DIST_MAX;
      best_v_q    <= 1'b0;
      best_mesh_q <= '0;
      out_v_q     <= 1'b0;
      out_hit_q   <= 1'b0;
      out_dist_q  <= '0;
      out_mesh_q  <= '0;
    end else begin
      if (emit) out_v_q <= 1'b1;
      else if (out_v_q && res_o.ready) out_v_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (item_valid_i) begin
            e1_q    <= item_i.e1;
            e2_q    <= item_i.e2;
            s_q     <= item_i.s;
            mesh_q  <= item_i.mesh;
            last_q  <= item_i.last;
            hit_q   <= 1'b0;
            step_q  <= '0;
            chunk_q <= '0;
            pm_q    <= '0;
            state_q <= item_i.ok ? S_MUL : S_UPD;
          end
        end
        S_MUL: begin
          pm_q <= pm_d;
          if (chunk_q == CKW'(NCHUNK - 1)) begin
            state_q <= S_ACC;
          end else begin
            chunk_q <= chunk_q + 1'b1;
          end
        end
        S_ACC: begin
          acc_q <= sum;
          if (st.wr) begin
            case (st.dg)
              DS_P:    p_q[st.di] <= XW'(sum);
              DS_Q:    q_q[st.di] <= XW'(sum);
              DS_R:    r_q[st.di] <= sum;
              default: ;
            endcase
          end
          chunk_q <= '0;
          pm_q    <= '0;
          if (step_q == STEPW'(NSTEP - 1)) begin
            state_q <= S_NORM;
          end else begin
            step_q  <= step_q + 1'b1;
            state_q <= S_MUL;
          end
        end
        S_NORM: begin
          detz_q <= r_q[R_DET] == '0;
          if (r_q[R_DET][AW-1]) begin
            r_q[R_DET] <= -r_q[R_DET];
            r_q[R_U]   <= -r_q[R_U];
            r_q[R_V]   <= -r_q[R_V];
            r_q[R_T]   <= -r_q[R_T];
          end
          state_q <= S_CHK;
        end
        S_CHK: begin
          uv_q     <= r_q[R_U] + r_q[R_V];
          sgn_ok_q <= !detz_q && !r_q[R_U][AW-1] && !r_q[R_V][AW-1] &&
                      !r_q[R_T][AW-1] && (r_q[R_DET] >= r_q[R_U]);
          state_q  <= S_CHK2;
        end
        S_CHK2: begin
          if (!hit_ok) begin
            state_q <= S_UPD;
          end else if (sat) begin
            hit_q   <= 1'b1;
            dist_q  <= DIST_MAX;
            state_q <= S_UPD;
          end else begin
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            hit_q   <= 1'b1;
            dist_q  <= div_quo;
            state_q <= S_UPD;
          end
        end
        S_UPD: begin
          if (can_upd) begin
            if (last_q) begin
              out_hit_q   <= nb_v;
              out_dist_q  <= nb_v ? nb_t : '0;
              out_mesh_q  <= nb_v ? nb_m : '0;
              best_v_q    <= 1'b0;
              best_t_q    <= DIST_MAX;
              best_mesh_q <= '0;
            end else begin
              best_v_q    <= nb_v;
              best_t_q    <= nb_t;
              best_mesh_q <= nb_m;
            end
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// File: src/ray_triangle_closest_hit_unit.sv
// top level of the closest-hit ray caster: ray registers, apb port, front, queue, back
// depends on rtc_pkg, rtc_if, rtc_front, rtc_fifo, rtc_back
//
//  channel   dir   handshake      payload
//  tri_i     in    valid/ready    a_x..c_z (Q16.16), mesh_id, last
//  res_o     out   valid/ready    hit, distance (Q15.16 unsigned), hit_mesh
//  apb       in    psel/penable   origin_x/y/z, dir_x/y/z at byte address 4*index
//
// a hit passes the back end as: accept, 24 products each formed chunk by chunk in the multiply
// state and summed in the accumulate state, the normalize and check states, the divide, update;
// a miss or saturated hit skips the divide; an out of range mesh goes from accept to update.
// the shared multiplier and the divider set the pace of the back end. the front and a two-entry queue
// take new triangles while the back is busy; a waiting result stalls only the next last item.
// asynchronous active-low reset clears the ray to origin 0, direction +z, no hit kept.
module ray_triangle_closest_hit_unit import rtc_pkg::*; #(
  parameter int MESH_COUNT = 256,
  parameter int FRAC_BITS  = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [ADDRW-1:0] paddr,
  input  logic [DATAW-1:0] pwdata,
  output logic [DATAW-1:0] prdata,
  output logic             pready,
  rtc_in_if.sink           tri_i,
  rtc_out_if.source        res_o
);

  // ray registers
  logic signed [CRDW-1:0] origin_x_q, origin_y_q, origin_z_q;
  logic signed [DIRW-1:0] dir_x_q, dir_y_q, dir_z_q;
  cfg_reg_e               reg_idx;
  logic                   wr_en;

  // front to queue to back
  tri_t front_item, q_item;
  logic front_valid, front_ready, q_valid, q_pop;

  assign pready  = 1'b1;
  assign reg_idx = cfg_reg_e'(paddr[ADDRW-1:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q <= '0;
      origin_y_q <= '0;
      origin_z_q <= '0;
      dir_x_q    <= '0;
      dir_y_q    <= '0;
      dir_z_q    <= DIR_Z_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_ORIGIN_X: origin_x_q <= pwdata;
        REG_ORIGIN_Y: origin_y_q <= pwdata;
        REG_ORIGIN_Z: origin_z_q <= pwdata;
        REG_DIR_X:    dir_x_q    <= pwdata[DIRW-1:0];
        REG_DIR_Y:    dir_y_q    <= pwdata[DIRW-1:0];
        REG_DIR_Z:    dir_z_q    <= pwdata[DIRW-1:0];
        default:      ;
      endcase
    end
  end

  // readback, direction registers zero-extended
  always_comb begin
    case (reg_idx)
      REG_ORIGIN_X: prdata = origin_x_q;
      REG_ORIGIN_Y: prdata = origin_y_q;
      REG_ORIGIN_Z: prdata = origin_z_q;
      REG_DIR_X:    prdata = {{(DATAW-DIRW){1'b0}}, dir_x_q};
      REG_DIR_Y:    prdata = {{(DATAW-DIRW){1'b0}}, dir_y_q};
      REG_DIR_Z:    prdata = {{(DATAW-DIRW){1'b0}}, dir_z_q};
      default:      prdata = '0;
    endcase
  end

  // edges and mesh check
  rtc_front #(.MESH_COUNT(MESH_COUNT)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tri_i        (tri_i),
    .origin_x_i   (origin_x_q),
    .origin_y_i   (origin_y_q),
    .origin_z_i   (origin_z_q),
    .item_o       (front_item),
    .item_valid_o (front_valid),
    .item_ready_i (front_ready)
  );

  rtc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_valid),
    .data_i  (front_item),
    .ready_o (front_ready),
    .valid_o (q_valid),
    .data_o  (q_item),
    .pop_i   (q_pop)
  );

  // intersection arithmetic and closest-hit tracking
  rtc_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .dir_x_i      (dir_x_q),
    .dir_y_i      (dir_y_q),
    .dir_z_i      (dir_z_q),
    .item_i       (q_item),
    .item_valid_i (q_valid),
    .item_ready_o (q_pop),
    .res_o        (res_o)
  );

endmodule

// File: src/rtc_checker.sv
// port-level checks of the result channel, bound to the top level
// depends on rtc_pkg, ray_triangle_closest_hit_unit
module rtc_checker import rtc_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic             out_hit_i,
  input logic [DISTW-1:0] out_distance_i,
  input logic [MESHW-1:0] out_mesh_i
);

  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_hit_i) && $stable(out_distance_i) &&
                                   $stable(out_mesh_i))
    else $error("result changed while stalled");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_hit_i |-> out_distance_i == '0 && out_mesh_i == '0)
    else $error("miss carries nonzero distance or mesh");

  a_hit_dist: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_hit_i |-> out_distance_i != '0)
    else $error("hit with zero distance");

endmodule

bind ray_triangle_closest_hit_unit rtc_checker u_rtc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (res_o.valid),
  .out_ready_i    (res_o.ready),
  .out_hit_i      (res_o.hit),
  .out_distance_i (res_o.distance),
  .out_mesh_i     (res_o.hit_mesh)
);
